// ===== rtl/core/zltd_pkg.sv =====
// shared types and constants for the legacy zip decrypt unit with utf-8 check
// holds key init values, the key multiplier and the crc-32 lookup table
// no dependencies
package zltd_pkg;

  localparam logic [31:0] KEY0_INIT = 32'h1234_5678;
  localparam logic [31:0] KEY1_INIT = 32'h2345_6789;
  localparam logic [31:0] KEY2_INIT = 32'h3456_7890;
  localparam logic [31:0] KEY_MULT  = 32'd134775813;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

  localparam int unsigned CRC_DEPTH = 256;
  localparam int unsigned CRC_AW    = $clog2(CRC_DEPTH);

  // action codes carried on the input tuser
  localparam logic ACT_MIX     = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  typedef logic [31:0] crc_table_t [CRC_DEPTH];

  typedef struct packed {
    logic       ok;
    logic [1:0] pending;
  } utf8_stat_t;

  // reflected crc-32 table, built at elaboration
  function automatic crc_table_t crc_build();
    crc_table_t tbl;
    logic [31:0] c;
    for (int i = 0; i < CRC_DEPTH; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      tbl[i] = c;
    end
    return tbl;
  endfunction

  localparam crc_table_t CRC_TABLE = crc_build();

endpackage

// ===== rtl/core/zltd_crc_rom.sv =====
// crc-32 lookup rom with one registered read port
// read data appears in the cycle after a read enable; depends on zltd_pkg
module zltd_crc_rom import zltd_pkg::*; (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [CRC_AW-1:0] rd_addr_i,
  output logic [31:0]       rd_data_o
);

  logic [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= CRC_TABLE[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/zltd_utf8_chk.sv =====
// utf-8 plausibility checker: 2- and 3-byte sequences only, sticky violation
// keeps pending continuation count and violation flag; depends on zltd_pkg
module zltd_utf8_chk import zltd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clear_i,
  input  logic       en_i,
  input  logic [7:0] byte_i,
  output utf8_stat_t stat_o
);

  logic [1:0] pend_q, pend_d;
  logic       viol_q, viol_d;

  always_comb begin
    pend_d = pend_q;
    viol_d = viol_q;
    if (clear_i) begin
      pend_d = 2'd0;
      viol_d = 1'b0;
    end else if (en_i) begin
      if (pend_q != 2'd0) begin
        if (byte_i[7:6] != 2'b10) begin
          viol_d = 1'b1;
        end
        pend_d = pend_q - 2'd1;
      end else if (byte_i[7]) begin
        // count leading ones of a lead byte
        if (!byte_i[6]) begin
          viol_d = 1'b1;
        end else if (!byte_i[5]) begin
          pend_d = 2'd1;
        end else if (!byte_i[4]) begin
          pend_d = 2'd2;
        end else begin
          viol_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      viol_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      viol_q <= viol_d;
    end
  end

  assign stat_o.ok      = !viol_q;
  assign stat_o.pending = pend_q;

endmodule

// ===== rtl/core/zip_legacy_decrypt_utf8_check_unit.sv =====
// legacy zip stream decryption with utf-8 check, one byte at a time
// cipher byte: states mul, addr0, k0, k1, addr2, k2, then back to idle for the next byte, with the result
// loaded in k2, which waits while the output register is full; password byte: same without mul, no result
// the byte time is set by the keystream multiply, two dependent reads of the crc rom
// and the key_one constant multiply, each with a register behind it
// reset: keys load their init values, checker clears, no result pending
module zip_legacy_decrypt_utf8_check_unit import zltd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] data_byte, [8] start_new, [15:9] zero
  input  logic        s_axis_tuser_i,   // [0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [7:0] plain_byte, [8] utf8_ok,
                                        // [10:9] continuations_pending, [15:11] zero
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDR0,
    ST_K0,
    ST_K1,
    ST_ADDR2,
    ST_K2
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] key0_q, key0_d;
  logic [31:0] key1_q, key1_d;
  logic [31:0] key2_q, key2_d;
  logic [31:0] sum_q, sum_d;
  logic [7:0]  byte_q, byte_d;
  logic        act_q, act_d;
  logic [7:0]  ks_q, ks_d;
  logic [7:0]  plain_q, plain_d;
  logic        ovalid_q, ovalid_d;
  logic [15:0] odata_q, odata_d;

  logic              accept;
  logic              start_new;
  logic              rom_en;
  logic [CRC_AW-1:0] rom_addr;
  logic [31:0]       rom_data;
  logic [15:0]       ks_t;
  logic [31:0]       ks_prod;
  logic [31:0]       key0_new;
  logic              chk_en;
  utf8_stat_t        chk_stat;
  logic              out_free;

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign start_new = s_axis_tdata_i[8];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free  = !ovalid_q || m_axis_tready_i;

  assign ks_t     = key2_q[15:0] | 16'h0002;
  assign ks_prod  = 32'(ks_t) * 32'(ks_t ^ 16'h0001);
  assign key0_new = rom_data ^ (key0_q >> 8);

  zltd_crc_rom u_rom (
    .clk_i     (clk_i),
    .rd_en_i   (rom_en),
    .rd_addr_i (rom_addr),
    .rd_data_o (rom_data)
  );

  zltd_utf8_chk u_chk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (accept && start_new),
    .en_i    (chk_en),
    .byte_i  (plain_d),
    .stat_o  (chk_stat)
  );

  always_comb begin
    state_d  = state_q;
    key0_d   = key0_q;
    key1_d   = key1_q;
    key2_d   = key2_q;
    sum_d    = sum_q;
    byte_d   = byte_q;
    act_d    = act_q;
    ks_d     = ks_q;
    plain_d  = plain_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    rom_en   = 1'b0;
    rom_addr = '0;
    chk_en   = 1'b0;

    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          byte_d = s_axis_tdata_i[7:0];
          act_d  = s_axis_tuser_i;
          if (start_new) begin
            key0_d = KEY0_INIT;
            key1_d = KEY1_INIT;
            key2_d = KEY2_INIT;
          end
          state_d = (s_axis_tuser_i == ACT_DECRYPT) ? ST_MUL : ST_ADDR0;
        end
      end
      ST_MUL: begin
        ks_d    = ks_prod[15:8];
        state_d = ST_ADDR0;
      end
      ST_ADDR0: begin
        plain_d  = (act_q == ACT_DECRYPT) ? (byte_q ^ ks_q) : byte_q;
        chk_en   = (act_q == ACT_DECRYPT);
        rom_en   = 1'b1;
        rom_addr = key0_q[7:0] ^ plain_d;
        state_d  = ST_K0;
      end
      ST_K0: begin
        key0_d  = key0_new;
        sum_d   = key1_q + 32'(key0_new[7:0]);
        state_d = ST_K1;
      end
      ST_K1: begin
        key1_d  = 32'(sum_q * KEY_MULT) + 32'd1;
        state_d = ST_ADDR2;
      end
      ST_ADDR2: begin
        rom_en   = 1'b1;
        rom_addr = key2_q[7:0] ^ key1_q[31:24];
        state_d  = ST_K2;
      end
      ST_K2: begin
        // a result waits here until the output register frees up
        if (act_q == ACT_MIX || out_free) begin
          key2_d = rom_data ^ (key2_q >> 8);
          if (act_q == ACT_DECRYPT) begin
            ovalid_d = 1'b1;
            odata_d  = {5'd0, chk_stat.pending, chk_stat.ok, plain_q};
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      key0_q   <= KEY0_INIT;
      key1_q   <= KEY1_INIT;
      key2_q   <= KEY2_INIT;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      key0_q   <= key0_d;
      key1_q   <= key1_d;
      key2_q   <= key2_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    byte_q  <= byte_d;
    act_q   <= act_d;
    ks_q    <= ks_d;
    plain_q <= plain_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

  // the checker never expects more than two continuation bytes
  a_pending_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[10:9] != 2'd3))
    else $error("continuation count out of range");

  // a start word reloads the keys before any key update
  a_start_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && start_new) |=> (key0_q == KEY0_INIT && key2_q == KEY2_INIT))
    else $error("keys not reloaded on start");

  // a new result is loaded only from the final key step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ovalid_q || m_axis_tready_i) ##1 ovalid_q |-> $past(state_q == ST_K2))
    else $error("result loaded outside final key step");

  // the input side is closed while a word is being worked on
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("input accepted during processing");

endmodule
